FILE: rtl/core/b2d_pkg.sv
package b2d_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0]    ASCII_ZERO = CHAR_W'(48);
    localparam logic [DIGIT_W-1:0]   DIGIT_MAX  = DIGIT_W'(9);
    localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_W - 1);

    // Packed BCD word, digit 0 is the least significant.
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    // Finished conversion handed from the converter to the emitter.
    typedef struct packed {
        logic valid;
        t_bcd digits;
    } t_conv_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_conv_state;

endpackage

FILE: rtl/core/b2d_in_if.sv
interface b2d_in_if
    import b2d_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/core/b2d_out_if.sv
interface b2d_out_if
    import b2d_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

FILE: rtl/core/binary_to_decimal_ascii_digits_top.sv
// An accepted word passes through the converter, then is loaded into the emitter, which sends its digits.
// A run holds 1 to 10 digit words, one per cycle while the output is ready.
// The converter takes no new word until its 32-step bit-serial shift-and-add-3 loop
// is done and the emitter has taken the result; it converts while the emitter sends.
// Reset is synchronous and active low; it empties the converter and the emitter.
module binary_to_decimal_ascii_digits_top
    import b2d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    b2d_in_if.sink    i_in,
    b2d_out_if.source o_out
);

    t_conv_out conv;
    logic      conv_ready;

    b2d_dabble u_dabble (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_conv       (conv),
        .i_conv_ready (conv_ready)
    );

    b2d_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_conv       (conv),
        .o_conv_ready (conv_ready),
        .o_out        (o_out)
    );

endmodule

FILE: rtl/core/b2d_dabble.sv
module b2d_dabble
    import b2d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    b2d_in_if.sink    i_in,
    output t_conv_out o_conv,
    input  logic      i_conv_ready
);

    t_conv_state                  r_state, n_state;
    logic [VALUE_W-1:0]           r_bin, n_bin;
    t_bcd                         r_bcd, n_bcd;
    logic [BIT_CNT_W-1:0]         r_cnt, n_cnt;
    t_bcd                         adj;
    logic [NUM_DIGITS*DIGIT_W-1:0] adj_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    // Every digit of five or more gets three added before the shift, so that
    // doubling carries correctly into the next decimal digit.
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            adj[k] = (r_bcd[k] >= DIGIT_W'(5)) ? r_bcd[k] + DIGIT_W'(3) : r_bcd[k];
        end
    end

    // Flat view of the adjusted digits, so the shift works across digit boundaries.
    assign adj_bits = adj;

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_bin   = i_in.value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_bcd = t_bcd'({adj_bits[NUM_DIGITS*DIGIT_W-2:0], r_bin[VALUE_W-1]});
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + BIT_CNT_W'(1);
                if (r_cnt == LAST_BIT) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_conv_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_conv.valid  = (r_state == ST_DONE);
    assign o_conv.digits = r_bcd;

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_RUN && r_cnt == '0))
        else $error("conversion did not start from bit zero");

    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cnt == LAST_BIT) |=> (r_state == ST_DONE))
        else $error("conversion did not finish after the last bit");

endmodule

FILE: rtl/core/b2d_emit.sv
module b2d_emit
    import b2d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_conv_out i_conv,
    output logic      o_conv_ready,
    b2d_out_if.source o_out
);

    t_bcd                 r_digits;
    logic [DIG_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIG_CNT_W-1:0] sig_cnt;
    logic [DIG_IDX_W-1:0] sel_idx;
    logic [DIGIT_W-1:0]   sel_digit;
    logic                 load;
    logic                 out_fire;

    // Number of significant digits; zero still shows one digit.
    always_comb begin
        sig_cnt = DIG_CNT_W'(1);
        for (int k = 1; k < NUM_DIGITS; k++) begin
            if (i_conv.digits[k] != '0) begin
                sig_cnt = DIG_CNT_W'(k + 1);
            end
        end
    end

    assign out_fire     = o_out.valid && o_out.ready;
    assign o_conv_ready = (r_cnt == '0) || (r_cnt == DIG_CNT_W'(1) && o_out.ready);
    assign load         = i_conv.valid && o_conv_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (load) begin
            n_cnt = sig_cnt;
        end else if (out_fire) begin
            n_cnt = r_cnt - DIG_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_digits <= i_conv.digits;
        end
    end

    // The remaining count points at the next digit to send, most significant first.
    assign sel_idx   = (r_cnt == '0) ? '0 : DIG_IDX_W'(r_cnt - DIG_CNT_W'(1));
    assign sel_digit = r_digits[sel_idx];

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.digit_char = ASCII_ZERO + CHAR_W'(sel_digit);
    assign o_out.last_digit = (r_cnt == DIG_CNT_W'(1));

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DIG_CNT_W'(NUM_DIGITS))
        else $error("digit count out of range");

    a_digit_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (sel_digit <= DIGIT_MAX))
        else $error("non-decimal digit presented");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_out.last_digit && !i_conv.valid) |=> (r_cnt == '0))
        else $error("digits left over after the last digit");

endmodule
